// File: sv/spq_pkg.sv
// Shared types and constants of the stable priority task queue.
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 128;
    localparam int S_TDATA_W        = 24;
    localparam int M_TDATA_W        = 32;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_EXEC   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_DELETE
    } ctrl_state_t;

    // The operation that every cell of the chain performs.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] prio;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_ctl_t;

    // Input transaction, last declared field in the lowest bits.
    typedef struct packed {
        logic [5:0] pad;
        logic [7:0] target_id;
        logic [7:0] new_priority;
        cmd_t       command;
    } in_item_t;

    // Result transaction, last declared field in the lowest bits.
    typedef struct packed {
        logic [5:0] pad;
        logic [7:0] entry_count;
        logic [7:0] task_priority;
        logic [7:0] task_id;
        status_t    status;
    } out_item_t;

endpackage

// File: sv/stable_priority_task_queue.sv
// Stable priority task queue: a chain of sorted cells with a command sequencer.
// Add, execute and no-op accept one transaction per cycle while the result slot is free;
// the result is registered and shows on m_tvalid the cycle after acceptance.
// Delete walks the list by rotating it through the head cell, one entry per cycle while the
// result slot is free, and accepts no new command until each queued entry has been visited.
// Reset (aresetn low at a clock edge) empties the queue and drops any pending result.
module stable_priority_task_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Command transaction.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // command[1:0], new_priority[9:2], target_id[17:10]
    // Result transaction.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status[1:0], task_id[9:2], task_priority[17:10],
                                            // entry_count[25:18]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_ctl_t        ctl;
    logic [CNT_W-1:0] occ;
    entry_t           cell_entry [CAPACITY];
    logic             cell_keep  [CAPACITY];

    // The sequencer owns the count and the result register, and steers the whole chain
    // with one shared operation per cycle.
    spq_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .head_entry (cell_entry[0]),
        .ctl        (ctl),
        .occ        (occ)
    );

    // Cell 0 is the head. On insert, each cell weighs its own entry, the new entry and its left
    // neighbor's entry and keep flag; on removal, every cell but the last takes its right neighbor.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic   occupied;
        logic   is_tail;
        entry_t left_entry;
        logic   left_keep;
        entry_t right_entry;

        assign occupied = (CNT_W'(i) < occ);
        assign is_tail  = (CNT_W'(i + 1) == occ);

        if (i == 0) begin : g_head
            assign left_entry = ctl.new_entry;
            assign left_keep  = 1'b1;
        end else begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_keep  = cell_keep[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_entry = cell_entry[i];
        end else begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .occupied    (occupied),
            .is_tail     (is_tail),
            .left_entry  (left_entry),
            .left_keep   (left_keep),
            .right_entry (right_entry),
            .head_entry  (cell_entry[0]),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

endmodule

// File: sv/spq_cell.sv
// One storage cell of the sorted queue chain.
module spq_cell
    import spq_pkg::*;
(
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  logic      occupied,
    input  logic      is_tail,
    input  entry_t    left_entry,
    input  logic      left_keep,
    input  entry_t    right_entry,
    input  entry_t    head_entry,
    output entry_t    entry,
    output logic      keep
);

    entry_t entry_reg;
    entry_t entry_next;

    // An occupied cell keeps its entry on insert when that entry ranks at or above the new one.
    assign keep  = occupied && (entry_reg.prio >= ctl.new_entry.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        case (ctl.op)
            CELL_HOLD: begin
                entry_next = entry_reg;
            end
            CELL_INSERT: begin
                if (keep) begin
                    entry_next = entry_reg;
                end else if (left_keep) begin
                    entry_next = ctl.new_entry;
                end else begin
                    entry_next = left_entry;
                end
            end
            CELL_SHIFT: begin
                entry_next = right_entry;
            end
            CELL_ROTATE: begin
                entry_next = is_tail ? head_entry : right_entry;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// File: sv/spq_ctrl.sv
// Command sequencer, occupancy count and result register of the task queue.
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  entry_t               head_entry,
    output cell_ctl_t            ctl,
    output logic [CNT_W-1:0]     occ
);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic             found_reg, found_next;
    logic [7:0]       target_reg, target_next;
    entry_t           hold_reg, hold_next;
    logic             m_tvalid_reg, m_tvalid_next;
    out_item_t        m_item_reg, m_item_next;

    in_item_t         in_item;
    logic             out_free;
    logic             hit;

    function automatic logic [7:0] low8(input logic [CNT_W-1:0] v);
        logic [CNT_W+7:0] w;
        w = {8'd0, v};
        return w[7:0];
    endfunction

    assign in_item  = in_item_t'(s_tdata);
    assign out_free = !m_tvalid_reg || m_tready;
    assign hit      = !found_reg && (head_entry.id == target_reg);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_item_reg);
    assign occ      = occ_reg;

    always_comb begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        steps_next    = steps_reg;
        found_next    = found_reg;
        target_next   = target_reg;
        hold_next     = hold_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_item_next   = m_item_reg;
        ctl.op        = CELL_HOLD;
        ctl.new_entry = '{id: low8(CNT_W'(occ_reg + 1'b1)), prio: in_item.new_priority};
        s_tready      = (state_reg == CTRL_IDLE) && out_free;

        case (state_reg)
            CTRL_IDLE: begin
                if (s_tvalid && s_tready) begin
                    m_item_next = '0;
                    case (in_item.command)
                        CMD_ADD: begin
                            m_tvalid_next = 1'b1;
                            if (occ_reg == CNT_W'(CAPACITY)) begin
                                m_item_next.status      = ST_FULL;
                                m_item_next.entry_count = low8(occ_reg);
                            end else begin
                                ctl.op                    = CELL_INSERT;
                                occ_next                  = CNT_W'(occ_reg + 1'b1);
                                m_item_next.status        = ST_OK;
                                m_item_next.task_id       = ctl.new_entry.id;
                                m_item_next.task_priority = in_item.new_priority;
                                m_item_next.entry_count   = low8(occ_next);
                            end
                        end
                        CMD_EXEC: begin
                            m_tvalid_next = 1'b1;
                            if (occ_reg == '0) begin
                                m_item_next.status = ST_EMPTY;
                            end else begin
                                ctl.op                    = CELL_SHIFT;
                                occ_next                  = CNT_W'(occ_reg - 1'b1);
                                m_item_next.status        = ST_OK;
                                m_item_next.task_id       = head_entry.id;
                                m_item_next.task_priority = head_entry.prio;
                                m_item_next.entry_count   = low8(occ_next);
                            end
                        end
                        CMD_DELETE: begin
                            if (occ_reg == '0) begin
                                m_tvalid_next      = 1'b1;
                                m_item_next.status = ST_EMPTY;
                            end else begin
                                state_next  = CTRL_DELETE;
                                steps_next  = occ_reg;
                                found_next  = 1'b0;
                                target_next = in_item.target_id;
                            end
                        end
                        default: begin
                            m_tvalid_next           = 1'b1;
                            m_item_next.status      = ST_OK;
                            m_item_next.entry_count = low8(occ_reg);
                        end
                    endcase
                end
            end
            CTRL_DELETE: begin
                // Unless stalled, each step drops the head (first match) or moves it to the tail.
                if (out_free) begin
                    steps_next = CNT_W'(steps_reg - 1'b1);
                    if (hit) begin
                        ctl.op     = CELL_SHIFT;
                        occ_next   = CNT_W'(occ_reg - 1'b1);
                        found_next = 1'b1;
                        hold_next  = head_entry;
                    end else begin
                        ctl.op = CELL_ROTATE;
                    end
                    if (steps_reg == CNT_W'(1)) begin
                        state_next              = CTRL_IDLE;
                        m_tvalid_next           = 1'b1;
                        m_item_next             = '0;
                        m_item_next.entry_count = low8(occ_next);
                        if (hit) begin
                            m_item_next.status        = ST_OK;
                            m_item_next.task_id       = head_entry.id;
                            m_item_next.task_priority = head_entry.prio;
                        end else if (found_reg) begin
                            m_item_next.status        = ST_OK;
                            m_item_next.task_id       = hold_reg.id;
                            m_item_next.task_priority = hold_reg.prio;
                        end else begin
                            m_item_next.status = ST_NOTFOUND;
                        end
                    end
                end
            end
            default: begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= CTRL_IDLE;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        steps_reg  <= steps_next;
        found_reg  <= found_next;
        target_reg <= target_next;
        hold_reg   <= hold_next;
        m_item_reg <= m_item_next;
    end

endmodule
